/* hdl/lcs_pkg.sv */
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared widths, register indexes and result codes for the LRU cache set.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int WAYS      = 16;
    localparam int TAG_W     = 32;
    localparam int RANK_W    = $clog2(WAYS);
    localparam int FILL_W    = $clog2(WAYS + 1);
    localparam int CAP_W     = 5;
    localparam int CFG_W     = 5;
    localparam int IDX_W     = 1;
    localparam int S_USER_W  = 2;
    localparam int S_DATA_W  = 32;
    localparam int OUT_W     = 2;
    localparam int M_DATA_W  = 8;

    typedef logic [OUT_W-1:0]  outcome_t;
    typedef logic [RANK_W-1:0] rank_t;
    typedef logic [FILL_W-1:0] fill_t;

    localparam outcome_t OUT_HIT         = 2'd0;
    localparam outcome_t OUT_MISS        = 2'd1;
    localparam outcome_t OUT_EVICT_CLEAN = 2'd2;
    localparam outcome_t OUT_EVICT_DIRTY = 2'd3;

    localparam logic [IDX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [IDX_W-1:0] CFG_WB_MODE  = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(WAYS);

endpackage

/* hdl/lru_cache_set_core.sv */
// ----------------------------------------------------------------------------
// lru_cache_set_core
// Fully associative cache set with least-recently-used replacement.
// ----------------------------------------------------------------------------
// The block takes one access item per cycle while it is not stalled and
// returns one outcome item for each, in order. An accepted item waits in the
// input register, where all 16 ways are compared against its tag and the tag,
// valid, dirty and recency state is updated; when it advances, its outcome is
// loaded into the result register, from which the outcome is offered.
// Back-to-back items see the state left by the one before them.
// Output stalls propagate to the input side only when both registers are full.
// Configuration writes must be issued while no item is in flight.
module lru_cache_set_core
    import lcs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_wdata,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [31:0] line_tag
    input  logic [S_USER_W-1:0] s_tuser,   // [0] command, [1] is_store
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [1:0] outcome, [7:2] zero
);

    logic [CAP_W-1:0] capacity_reg;
    logic             wb_mode_reg;

    logic             in_valid_reg;
    logic             in_cmd_reg;
    logic             in_store_reg;
    logic [TAG_W-1:0] in_tag_reg;

    logic             out_valid_reg;
    outcome_t         outcome_reg;
    outcome_t         outcome_next;

    logic [TAG_W-1:0] tag_reg   [WAYS];
    logic [WAYS-1:0]  valid_reg;
    logic [WAYS-1:0]  valid_next;
    logic [WAYS-1:0]  dirty_reg;
    logic [WAYS-1:0]  dirty_next;
    rank_t            rank_reg  [WAYS];
    rank_t            rank_next [WAYS];
    fill_t            fill_reg;
    fill_t            fill_next;

    logic             advance;
    logic [WAYS-1:0]  hit_vec;
    logic             hit;
    rank_t            hit_rank;
    logic [CAP_W-1:0] eff_cap;
    logic             full;
    rank_t            last_rank;
    logic [WAYS-1:0]  oldest_vec;
    logic             evict;
    logic [WAYS-1:0]  evict_vec;
    logic             evict_dirty;
    logic [WAYS-1:0]  free_vec;
    logic [WAYS-1:0]  slot_vec;
    logic             insert;
    logic [WAYS-1:0]  survive_vec;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - OUT_W){1'b0}}, outcome_reg};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
            wb_mode_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CAPACITY: capacity_reg <= cfg_wdata[CAP_W-1:0];
                CFG_WB_MODE:  wb_mode_reg  <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        hit_rank = '0;
        for (int i = 0; i < WAYS; i++)
        begin
            hit_vec[i]    = valid_reg[i] && (tag_reg[i] == in_tag_reg);
            if (hit_vec[i])
                hit_rank = hit_rank | rank_reg[i];
        end
        hit = |hit_vec;

        if (capacity_reg == '0)
            eff_cap = CAP_W'(1);
        else if (capacity_reg > CAP_W'(WAYS))
            eff_cap = CAP_W'(WAYS);
        else
            eff_cap = capacity_reg;
        full = CAP_W'(fill_reg) >= eff_cap;

        // Valid lines hold distinct ranks 0..fill-1, so the oldest has rank fill-1.
        last_rank = RANK_W'(fill_reg - fill_t'(1));
        for (int i = 0; i < WAYS; i++)
            oldest_vec[i] = valid_reg[i] && (rank_reg[i] == last_rank);

        evict       = in_cmd_reg && !hit && full && (|oldest_vec);
        evict_vec   = evict ? oldest_vec : '0;
        evict_dirty = |(evict_vec & dirty_reg);

        // Lowest free way after the eviction takes the new tag.
        free_vec    = ~valid_reg | evict_vec;
        slot_vec    = free_vec & (~free_vec + WAYS'(1));
        insert      = in_cmd_reg && !hit && (|free_vec);
        survive_vec = valid_reg & ~evict_vec;

        valid_next = valid_reg;
        dirty_next = dirty_reg;
        rank_next  = rank_reg;
        fill_next  = fill_reg;

        if (hit)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    rank_next[i] = rank_reg[i] + rank_t'(1);
                if (hit_vec[i])
                begin
                    rank_next[i]  = '0;
                    dirty_next[i] = wb_mode_reg;
                end
            end
        end
        else if (insert)
        begin
            for (int i = 0; i < WAYS; i++)
            begin
                if (survive_vec[i])
                    rank_next[i] = rank_reg[i] + rank_t'(1);
                if (evict_vec[i])
                begin
                    valid_next[i] = 1'b0;
                    dirty_next[i] = 1'b0;
                    rank_next[i]  = '0;
                end
                if (slot_vec[i])
                begin
                    valid_next[i] = 1'b1;
                    dirty_next[i] = wb_mode_reg && in_store_reg;
                    rank_next[i]  = '0;
                end
            end
            if (!evict)
                fill_next = fill_reg + fill_t'(1);
        end

        if (hit)
            outcome_next = OUT_HIT;
        else if (evict)
            outcome_next = evict_dirty ? OUT_EVICT_DIRTY : OUT_EVICT_CLEAN;
        else
            outcome_next = OUT_MISS;
    end

    // Input register, line state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            fill_reg      <= '0;
            for (int i = 0; i < WAYS; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                valid_reg <= valid_next;
                dirty_reg <= dirty_next;
                fill_reg  <= fill_next;
                rank_reg  <= rank_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_cmd_reg   <= s_tuser[0];
            in_store_reg <= s_tuser[1];
            in_tag_reg   <= s_tdata[TAG_W-1:0];
        end
        if (advance)
        begin
            outcome_reg <= outcome_next;
            if (insert)
            begin
                for (int i = 0; i < WAYS; i++)
                    if (slot_vec[i])
                        tag_reg[i] <= in_tag_reg;
            end
        end
    end

endmodule
